// ===== sv/hlf_pkg.sv =====
// shared types, character constants and helper functions for the hex line framer
`timescale 1ns / 1ps
package hlf_pkg;

  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] CRC_INIT = 32'hffffffff;

  // character positions within one queued beat
  localparam logic [3:0] POS_PREFIX = 4'd0;
  localparam logic [3:0] POS_HI     = 4'd4;
  localparam logic [3:0] POS_LO     = 4'd5;
  localparam logic [3:0] POS_COLON  = 4'd6;
  localparam logic [3:0] POS_CRC    = 4'd7;
  localparam logic [3:0] POS_NL     = 4'd15;

  localparam logic [6:0] CH_COLON   = 7'h3a;
  localparam logic [6:0] CH_NEWLINE = 7'h0a;
  localparam logic [6:0] CH_ZERO    = 7'h30;
  localparam logic [6:0] CH_A       = 7'h61;

  localparam logic [6:0] PREFIX [4] = '{7'h4d, 7'h43, 7'h32, 7'h3a};

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first;
    logic        last;
    logic [31:0] crc_out;
  } hlf_entry_t;

  function automatic logic [31:0] crc_fold(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [6:0] hex_char(input logic [3:0] n);
    logic [6:0] ch;
    if (n < 4'd10) ch = CH_ZERO + {3'd0, n};
    else ch = CH_A + {3'd0, n} - 7'd10;
    return ch;
  endfunction

  function automatic logic [6:0] char_at(input logic [3:0] pos, input hlf_entry_t e);
    logic [6:0] ch;
    logic [3:0] nib_from_nl;
    logic [2:0] nib;
    nib_from_nl = POS_NL - 4'd1 - pos;
    nib = nib_from_nl[2:0];
    if (pos < POS_HI) ch = PREFIX[pos[1:0]];
    else if (pos == POS_HI) ch = hex_char(e.data_byte[7:4]);
    else if (pos == POS_LO) ch = hex_char(e.data_byte[3:0]);
    else if (pos == POS_COLON) ch = CH_COLON;
    else if (pos < POS_NL) ch = hex_char(e.crc_out[{nib, 2'b00} +: 4]);
    else ch = CH_NEWLINE;
    return ch;
  endfunction

endpackage

// ===== sv/hlf_front.sv =====
// front end: line tracking and crc folding for each accepted byte
`timescale 1ns / 1ps
module hlf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_line_end,
  input  logic               q_full,
  output logic               q_push,
  output hlf_pkg::hlf_entry_t q_entry
);

  logic        inside_r, inside_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] crc_start, crc_fold_val;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    crc_start    = inside_r ? crc_r : hlf_pkg::CRC_INIT;
    crc_fold_val = hlf_pkg::crc_fold(crc_start, in_data_byte);
    q_entry.data_byte = in_data_byte;
    q_entry.first     = !inside_r;
    q_entry.last      = in_line_end;
    q_entry.crc_out   = ~crc_fold_val;
    inside_nxt = inside_r;
    crc_nxt    = crc_r;
    if (q_push) begin
      inside_nxt = !in_line_end;
      crc_nxt    = in_line_end ? hlf_pkg::CRC_INIT : crc_fold_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      crc_r    <= hlf_pkg::CRC_INIT;
    end else begin
      inside_r <= inside_nxt;
      crc_r    <= crc_nxt;
    end
  end

endmodule

// ===== sv/hlf_queue.sv =====
// short fifo of classified beats between front and back
`timescale 1ns / 1ps
module hlf_queue #(
  parameter int DEPTH = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  hlf_pkg::hlf_entry_t       push_entry,
  input  logic                      pop,
  output hlf_pkg::hlf_entry_t       head,
  output logic                      full,
  output logic                      empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

  hlf_pkg::hlf_entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign count = count_r;
  assign head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + PW'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + PW'(1);
    if (push && !pop) count_nxt = count_r + CW'(1);
    else if (pop && !push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== sv/hlf_back.sv =====
// back end: walks the characters of the head beat into the output register
`timescale 1ns / 1ps
module hlf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  hlf_pkg::hlf_entry_t head,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [6:0]          out_character,
  output logic                out_run_last
);

  logic       mid_r, mid_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [6:0] char_r, char_nxt;
  logic       last_r, last_nxt;
  logic [3:0] cur_pos, end_pos;
  logic       advance, emit, at_end;

  always_comb begin
    cur_pos = mid_r ? pos_r : (head.first ? hlf_pkg::POS_PREFIX : hlf_pkg::POS_HI);
    end_pos = head.last ? hlf_pkg::POS_NL : hlf_pkg::POS_LO;
    at_end  = (cur_pos == end_pos);
    advance = !out_valid_r || out_ready;
    emit    = advance && !q_empty;
    q_pop   = emit && at_end;

    mid_nxt       = mid_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    if (advance) out_valid_nxt = !q_empty;
    if (emit) begin
      char_nxt = hlf_pkg::char_at(cur_pos, head);
      last_nxt = at_end;
      mid_nxt  = !at_end;
      pos_nxt  = cur_pos + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mid_r       <= mid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = char_r;
  assign out_run_last  = last_r;

endmodule

// ===== sv/hex_line_framer_crc32.sv =====
// top level of the hex line framer with crc-32 trailer
`timescale 1ns / 1ps
// usage:
//   input channel (in_valid/in_ready) takes one record byte per beat with
//   in_line_end marking the last byte of a line.
//   output channel (out_valid/out_ready) gives one ascii character per beat;
//   out_run_last flags the last character caused by an input byte.
//   a line reads "MC2:" + two hex digits per byte + ":" + eight hex digits of
//   the inverted reflected crc-32 + newline.
// a byte is classified and crc-folded in the cycle it is accepted, then
//   passes through the queue and the output character register before its
//   first character appears.
// throughput: while out_ready is high the back end emits one character per
//   cycle, so a byte gives 2 characters (middle), 6 (line start), 12 (line
//   end) or 16 (one-byte line); the output character register sets that pace.
// the queue of QUEUE_DEPTH beats lets the front keep accepting while the
//   back is still spelling out an earlier byte.
// reset: synchronous active low; queue empties, output goes invalid, the
//   next byte starts a new line with a fresh crc.
// stall: when out_ready is low the character holds, the queue fills and
//   in_ready drops once it is full.
module hex_line_framer_crc32 #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_line_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_character,
  output logic       out_run_last
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  hlf_pkg::hlf_entry_t push_entry, head;
  logic                q_push, q_pop, q_full, q_empty;
  logic [CW-1:0]       q_count;

  // front: line state and crc per byte
  hlf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_line_end  (in_line_end),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  // decoupling queue
  hlf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty),
    .count      (q_count)
  );

  // back: character sequencer and output register
  hlf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_run_last  (out_run_last)
  );

  // queue never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

  // a lone push grows the fill level by one
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_pop) |=> (q_count == $past(q_count) + CW'(1)))
    else $error("queue count did not follow push");

  // a popped beat always ends with a flagged character
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid && out_run_last))
    else $error("beat retired without last flag");

endmodule
